[src/tlpq_pkg.sv]
package tlpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int LEVELS     = 3;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int LVL_W   = 2;
  localparam int STAT_W  = 2;
  localparam int WORD_W  = 32;

  localparam logic [LVL_W-1:0] LVL_LOWEST = LVL_W'(LEVELS - 1);

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

[src/three_level_priority_queue.sv]
// three-level priority queue over one shared pool of slots
//
// input channel (in_valid / in_stall): mode 0 enqueues payload at level
// (0 highest, 2 lowest; level 3 is taken as 2), mode 1 dequeues the oldest
// word of the highest non-empty level. every word yields one result word.
// output channel (out_valid / out_stall): status ok, empty (dequeue with
// nothing stored) or full (enqueue with no free slot); out_payload and
// out_level carry the dequeued entry and are zero otherwise.
//
// an accepted word is captured in the operation registers; its result is
// written to the output register by its write-back state.
// the accept reads the free-slot stack, or the entry and link memories,
// into registers; the write-back state writes links, heads, tails and
// counts. a new word is accepted only after the write-back, so accesses
// to the same slot never overlap.
// a result that is stalled stays in the output register; the next word is
// still accepted and waits in its write-back cycle until the register frees.
// reset empties all levels and makes all slots free at once: a low-water
// mark on the free-slot stack stands in for its initial contents.
module three_level_priority_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [tlpq_pkg::LVL_W-1:0]      level,
  input  logic [31:0]                     payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tlpq_pkg::STAT_W-1:0]     status,
  output logic [31:0]                     out_payload,
  output logic [tlpq_pkg::LVL_W-1:0]      out_level
);
  import tlpq_pkg::*;

  // memories
  logic [DATA_WIDTH-1:0] entry_mem [CAPACITY];
  logic [ADDR_W-1:0]     link_mem  [CAPACITY];
  logic [ADDR_W-1:0]     free_mem  [CAPACITY];

  logic [DATA_WIDTH-1:0] entry_q;
  logic [ADDR_W-1:0]     link_q;
  logic [ADDR_W-1:0]     free_q;

  // control state
  state_t            state;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  low_mark;
  logic [ADDR_W-1:0] heads  [LEVELS];
  logic [ADDR_W-1:0] tails  [LEVELS];
  logic [CNT_W-1:0]  counts [LEVELS];

  // current operation
  mode_t                 op_mode;
  logic [LVL_W-1:0]      op_lvl;
  logic                  op_ok;
  logic                  op_fresh;
  logic [ADDR_W-1:0]     op_faddr;
  logic [ADDR_W-1:0]     op_slot;
  logic [DATA_WIDTH-1:0] op_word;

  logic                  accept;
  logic                  exec_go;
  logic [LVL_W-1:0]      enq_lvl;
  logic [LVL_W-1:0]      deq_lvl;
  logic                  deq_any;
  logic [CNT_W-1:0]      fc_dec;
  logic [ADDR_W-1:0]     new_slot;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign exec_go  = (state == S_EXEC) && !(out_valid && out_stall);

  assign enq_lvl = (level > LVL_LOWEST) ? LVL_LOWEST : level;
  assign fc_dec  = free_count - CNT_W'(1);

  always_comb begin
    deq_any = 1'b0;
    deq_lvl = LVL_LOWEST;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (counts[l] != '0) begin
        deq_any = 1'b1;
        deq_lvl = LVL_W'(l);
      end
    end
  end

  // stack positions below the low-water mark were never written and hold their own index
  assign new_slot = op_fresh ? op_faddr : free_q;

  // read side
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_ENQ) begin
      free_q <= free_mem[fc_dec[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_DEQ) begin
      entry_q <= entry_mem[heads[deq_lvl]];
      link_q  <= link_mem[heads[deq_lvl]];
    end
  end

  // write side
  always_ff @(posedge clk) begin
    if (exec_go && op_ok && op_mode == MODE_ENQ) begin
      entry_mem[new_slot] <= op_word;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && op_ok && op_mode == MODE_ENQ && counts[op_lvl] != '0) begin
      link_mem[tails[op_lvl]] <= new_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && op_ok && op_mode == MODE_DEQ && free_count < CNT_W'(CAPACITY)) begin
      free_mem[free_count[ADDR_W-1:0]] <= op_slot;
    end
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= mode_t'(mode);
      op_word  <= DATA_WIDTH'(payload);
      op_faddr <= fc_dec[ADDR_W-1:0];
      op_fresh <= (free_count <= low_mark);
      op_slot  <= heads[deq_lvl];
      if (mode == MODE_ENQ) begin
        op_lvl <= enq_lvl;
        op_ok  <= (free_count != '0);
      end else begin
        op_lvl <= deq_lvl;
        op_ok  <= deq_any;
      end
    end
  end

  // control and list state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= CNT_W'(CAPACITY);
      low_mark   <= CNT_W'(CAPACITY);
      for (int l = 0; l < LEVELS; l++) begin
        heads[l]  <= '0;
        tails[l]  <= '0;
        counts[l] <= '0;
      end
    end else begin
      if (accept) begin
        state <= S_EXEC;
      end
      if (exec_go) begin
        state <= S_IDLE;
        if (op_ok && op_mode == MODE_ENQ) begin
          if (counts[op_lvl] == '0) begin
            heads[op_lvl] <= new_slot;
          end
          tails[op_lvl]  <= new_slot;
          counts[op_lvl] <= counts[op_lvl] + CNT_W'(1);
          free_count     <= fc_dec;
          if (fc_dec < low_mark) begin
            low_mark <= fc_dec;
          end
        end else if (op_ok && op_mode == MODE_DEQ) begin
          counts[op_lvl] <= counts[op_lvl] - CNT_W'(1);
          if (counts[op_lvl] == CNT_W'(1)) begin
            heads[op_lvl] <= '0;
            tails[op_lvl] <= '0;
          end else begin
            heads[op_lvl] <= link_q;
          end
          if (free_count < CNT_W'(CAPACITY)) begin
            free_count <= free_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      if (!op_ok) begin
        status <= (op_mode == MODE_ENQ) ? ST_FULL : ST_EMPTY;
      end else begin
        status <= ST_OK;
      end
      if (op_ok && op_mode == MODE_DEQ) begin
        out_payload <= 32'(entry_q);
        out_level   <= op_lvl;
      end else begin
        out_payload <= '0;
        out_level   <= '0;
      end
    end
  end

endmodule

[src/tlpq_checker.sv]
module tlpq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tlpq_pkg::STAT_W-1:0] status,
  input logic [31:0]                 out_payload,
  input logic [tlpq_pkg::LVL_W-1:0]  out_level
);
  import tlpq_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_payload)
      && $stable(out_level))
    else $error("stalled result changed");

  // only dequeue hits carry data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> out_payload == '0 && out_level == '0)
    else $error("non-ok result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL)
      && out_level != 2'd3)
    else $error("bad status or level code");

  // one word in flight: input closes right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted during write-back");

  // each word accepted while no result is stalled yields a valid result after its write-back
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !(out_valid && out_stall) |=> ##1 out_valid)
    else $error("result missing after accept");

endmodule

bind three_level_priority_queue tlpq_checker u_tlpq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .out_payload (out_payload),
  .out_level   (out_level)
);
